[rtl/core/sliding_window_retransmit_tracker_top_defines.svh]
// assertion helpers shared by the checker
`ifndef SLIDING_WINDOW_RETRANSMIT_TRACKER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_RETRANSMIT_TRACKER_TOP_DEFINES_SVH

// property checked on every rising edge, masked while reset is high
`define SWT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define SWT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/swt_pkg.sv]
package swt_pkg;

  // input function codes
  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_ACK  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;
  localparam logic [1:0] FUNC_NOP  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_RETX = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  // segment length clamp and retransmit limit per tick
  localparam int unsigned MAX_SEGMENT = 4095;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned RTX_W       = 4;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] segment_length;
    logic [31:0] ack_number;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [2:0]  slot_index;
    logic [31:0] seq_start;
    logic [31:0] window_base;
    logic [3:0]  busy_slots;
    logic        outstanding;
    logic        last;
  } result_t;

  // which result the datapath loads into the output register
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_SEND,
    EMIT_FULL,
    EMIT_ZERO,
    EMIT_ACK,
    EMIT_HOLD_MID,
    EMIT_HOLD_LAST
  } emit_t;

  // controller to datapath
  typedef struct packed {
    logic  latch;
    logic  adv;
    logic  idx_clr;
    logic  alloc;
    logic  free_slot;
    logic  restamp;
    emit_t emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       slot_busy;
    logic       len_zero;
    logic       acked;
    logic       due;
    logic       hold_valid;
    logic       idx_last;
    logic       out_free;
  } stat_t;

endpackage

[rtl/core/swt_ifs.sv]
// input item channel
interface swt_item_if;
  import swt_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result channel
interface swt_result_if;
  import swt_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// timeout register write channel
interface swt_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/swt_ram.sv]
module swt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/swt_ctrl.sv]
module swt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     in_func,
  output logic           in_ready,
  input  swt_pkg::stat_t stat,
  output swt_pkg::cmd_t  cmd
);
  import swt_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  // per-slot decisions
  always_comb begin
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (in_func != FUNC_NOP) begin
            state_next = SCAN;
          end
        end
      end
      SCAN: begin
        case (stat.op)
          FUNC_SEND: begin
            if (!stat.slot_busy) begin
              // lowest free slot found
              if (stat.out_free) begin
                cmd.emit    = stat.len_zero ? EMIT_ZERO : EMIT_SEND;
                cmd.alloc   = !stat.len_zero;
                cmd.idx_clr = 1'b1;
                state_next  = IDLE;
              end
            end else if (stat.idx_last) begin
              // window full
              if (stat.out_free) begin
                cmd.emit    = EMIT_FULL;
                cmd.idx_clr = 1'b1;
                state_next  = IDLE;
              end
            end else begin
              cmd.adv = 1'b1;
            end
          end
          FUNC_ACK: begin
            if (stat.idx_last) begin
              if (stat.out_free) begin
                cmd.free_slot = stat.acked;
                cmd.emit      = EMIT_ACK;
                cmd.idx_clr   = 1'b1;
                state_next    = IDLE;
              end
            end else begin
              cmd.free_slot = stat.acked;
              cmd.adv       = 1'b1;
            end
          end
          FUNC_TICK: begin
            // a due slot pushes the held retransmit out first
            if (!(stat.due && stat.hold_valid && !stat.out_free)) begin
              if (stat.due) begin
                cmd.restamp = 1'b1;
                if (stat.hold_valid) begin
                  cmd.emit = EMIT_HOLD_MID;
                end
              end
              if (stat.idx_last) begin
                state_next = FLUSH;
              end else begin
                cmd.adv = 1'b1;
              end
            end
          end
          default: begin
            cmd.idx_clr = 1'b1;
            state_next  = IDLE;
          end
        endcase
      end
      FLUSH: begin
        // final retransmit of the tick carries last
        if (!stat.hold_valid) begin
          cmd.idx_clr = 1'b1;
          state_next  = IDLE;
        end else if (stat.out_free) begin
          cmd.emit    = EMIT_HOLD_LAST;
          cmd.idx_clr = 1'b1;
          state_next  = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

[rtl/core/swt_dp.sv]
module swt_dp #(
  parameter int unsigned WINDOW_SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  swt_pkg::item_t   in_data,
  input  logic             cfg_valid,
  input  logic [31:0]      cfg_data,
  output logic             out_valid,
  input  logic             out_ready,
  output swt_pkg::result_t out_data,
  input  swt_pkg::cmd_t    cmd,
  output swt_pkg::stat_t   stat
);
  import swt_pkg::*;

  localparam int unsigned IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_SLOTS + 1);

  // latched item
  logic [1:0]        op_func;
  logic [11:0]       len_r;
  logic [31:0]       ack_r;
  logic              raise_r;

  // window state
  logic [31:0]       base;
  logic [31:0]       next;
  logic [31:0]       tick;
  logic [31:0]       timeout;
  logic [WINDOW_SLOTS-1:0] busy;
  logic [CNT_W-1:0]  cnt;

  // scan state
  logic [IDX_W-1:0]  idx;
  logic              hold_valid;
  logic [IDX_W-1:0]  hold_slot;
  logic [31:0]       hold_seq;
  logic [RTX_W-1:0]  rtx_n;

  // slot storage read data
  logic [63:0]       seq_rd;
  logic [31:0]       time_rd;
  logic [31:0]       seq_start_rd;
  logic [31:0]       seq_end_rd;
  logic [IDX_W-1:0]  rd_addr;
  logic              time_we;
  logic [11:0]       len_clamped;

  logic [31:0]       age;
  logic [31:0]       base_next;
  logic [31:0]       next_next;
  logic [CNT_W-1:0]  cnt_next;
  logic [31:0]       cnt_ext;
  logic [31:0]       idx_ext;
  logic [31:0]       hold_ext;
  result_t           res;

  assign seq_start_rd = seq_rd[31:0];
  assign seq_end_rd   = seq_rd[63:32];
  assign len_clamped  = (32'(in_data.segment_length) > MAX_SEGMENT) ?
                        12'(MAX_SEGMENT) : in_data.segment_length;

  // read address runs one slot ahead of the scan index
  assign rd_addr = cmd.idx_clr ? '0 : (cmd.adv ? idx + IDX_W'(1) : idx);
  assign time_we = cmd.alloc || cmd.restamp;

  swt_ram #(.WIDTH(64), .DEPTH(WINDOW_SLOTS)) u_seq_ram (
    .clk   (clk),
    .we    (cmd.alloc),
    .waddr (idx),
    .wdata ({next + 32'(len_r), next}),
    .raddr (rd_addr),
    .rdata (seq_rd)
  );

  swt_ram #(.WIDTH(32), .DEPTH(WINDOW_SLOTS)) u_time_ram (
    .clk   (clk),
    .we    (time_we),
    .waddr (idx),
    .wdata (tick),
    .raddr (rd_addr),
    .rdata (time_rd)
  );

  // status toward the controller
  assign age = tick - time_rd;
  always_comb begin
    stat            = '0;
    stat.op         = op_func;
    stat.slot_busy  = busy[idx];
    stat.len_zero   = (len_r == '0);
    stat.acked      = raise_r && busy[idx] && (seq_end_rd <= ack_r);
    stat.due        = busy[idx] && (age >= timeout) && (rtx_n < RTX_W'(MAX_RESULTS));
    stat.hold_valid = hold_valid;
    stat.idx_last   = (idx == IDX_W'(WINDOW_SLOTS - 1));
    stat.out_free   = !out_valid || out_ready;
  end

  // state after this cycle, as shown in the result
  assign base_next = (cmd.emit == EMIT_ACK && raise_r) ? ack_r : base;
  assign next_next = cmd.alloc ? next + 32'(len_r) : next;
  assign cnt_next  = cnt + CNT_W'(cmd.alloc) - CNT_W'(cmd.free_slot);
  assign cnt_ext   = 32'(cnt_next);
  assign idx_ext   = 32'(idx);
  assign hold_ext  = 32'(hold_slot);

  // result payload
  always_comb begin
    res             = '0;
    res.window_base = base_next;
    res.busy_slots  = cnt_ext[3:0];
    res.outstanding = (base_next < next_next);
    res.last        = 1'b1;
    unique case (cmd.emit) inside
      EMIT_SEND: begin
        res.kind       = KIND_SEND;
        res.status     = STAT_OK;
        res.slot_index = idx_ext[2:0];
        res.seq_start  = next;
      end
      EMIT_FULL: begin
        res.kind      = KIND_SEND;
        res.status    = STAT_FULL;
        res.seq_start = next;
      end
      EMIT_ZERO: begin
        res.kind      = KIND_SEND;
        res.status    = STAT_ZERO;
        res.seq_start = next;
      end
      EMIT_ACK: begin
        res.kind = KIND_ACK;
      end
      EMIT_HOLD_MID, EMIT_HOLD_LAST: begin
        res.kind       = KIND_RETX;
        res.slot_index = hold_ext[2:0];
        res.seq_start  = hold_seq;
        res.last       = (cmd.emit == EMIT_HOLD_LAST);
      end
      default: begin
        res.kind = KIND_SEND;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= '0;
      next       <= '0;
      tick       <= '0;
      timeout    <= TIMEOUT_RESET;
      busy       <= '0;
      cnt        <= '0;
      idx        <= '0;
      hold_valid <= 1'b0;
      rtx_n      <= '0;
      out_valid  <= 1'b0;
      op_func    <= FUNC_NOP;
    end else begin
      if (cfg_valid) begin
        timeout <= cfg_data;
      end
      if (cmd.latch) begin
        op_func    <= in_data.func;
        hold_valid <= 1'b0;
        rtx_n      <= '0;
        if (in_data.func == FUNC_TICK) begin
          tick <= tick + 32'd1;
        end
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.adv) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.alloc) begin
        busy[idx] <= 1'b1;
      end
      if (cmd.free_slot) begin
        busy[idx] <= 1'b0;
      end
      cnt  <= cnt_next;
      next <= next_next;
      base <= base_next;
      if (cmd.restamp) begin
        hold_valid <= 1'b1;
        rtx_n      <= rtx_n + RTX_W'(1);
      end else if (cmd.emit == EMIT_HOLD_LAST) begin
        hold_valid <= 1'b0;
      end
      // output register
      if (cmd.emit != EMIT_NONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      len_r   <= len_clamped;
      ack_r   <= in_data.ack_number;
      raise_r <= (in_data.ack_number > base);
    end
    if (cmd.restamp) begin
      hold_slot <= idx;
      hold_seq  <= seq_start_rd;
    end
    if (cmd.emit != EMIT_NONE) begin
      out_data <= res;
    end
  end

endmodule

[rtl/core/sliding_window_retransmit_tracker_top.sv]
// Sender-side window tracker for a sliding-window ARQ link.
// items: one transfer per command: send (segment_length), cumulative ack
//   (ack_number) or timer tick. results: send responses, ack responses and
//   retransmit requests; last marks the final result of a command.
// cfg: writes the retransmit timeout in ticks, taken at once (ready is
//   always high); write only while no command is in progress.
// Every real command walks the slots one per cycle, limited by the
//   single read port of the slot tables; the walk holds only while a result
//   is due and the output register is still full. A send stops at the lowest
//   free slot (the last when full); an ack and a tick walk every slot, and a
//   tick gives up to 8 retransmits. An unused function code gives no result.
// items.ready is high only between commands, so one command is in work at a
//   time. A finished result sits in an output register; a stalled receiver
//   holds the scan only when another result is due, and the next command is
//   taken while the last result still waits.
// Reset (rst, synchronous) frees all slots, clears base, next sequence and
//   tick count, sets the timeout to 1000 and drops results.valid.
module sliding_window_retransmit_tracker_top #(
  parameter int unsigned WINDOW_SLOTS = 8
) (
  input logic          clk,
  input logic          rst,
  swt_item_if.sink     items,
  swt_result_if.source results,
  swt_cfg_if.sink      cfg
);
  import swt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg.ready = 1'b1;

  swt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_func  (items.data.func),
    .in_ready (items.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swt_dp #(.WINDOW_SLOTS(WINDOW_SLOTS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (items.data),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

[rtl/core/swt_checker.sv]
`include "sliding_window_retransmit_tracker_top_defines.svh"

module swt_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [1:0]       in_func,
  input logic             res_valid,
  input logic             res_ready,
  input swt_pkg::result_t res
);
  import swt_pkg::*;

  // reset drops any pending result
  `SWT_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !res_valid, "result valid after reset")

  // a real command drops ready in the cycle after its transfer
  `SWT_ASSERT(a_one_cmd, clk, rst, in_valid && in_ready && in_func != FUNC_NOP |=> !in_ready, "command overlap")

  // a stalled result stays put until its transfer
  `SWT_ASSERT(a_hold_stable, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res), "result changed while stalled")

  // ack responses are single, plain results
  `SWT_ASSERT(a_ack_shape, clk, rst, res_valid && res.kind == KIND_ACK |-> res.last && res.status == STAT_OK && res.slot_index == 3'd0 && res.seq_start == 32'd0, "bad ack response")

  // refused sends report slot zero and close the command
  `SWT_ASSERT(a_refuse_shape, clk, rst, res_valid && res.kind == KIND_SEND && res.status != STAT_OK |-> res.slot_index == 3'd0 && res.last, "bad refused send")

endmodule

bind sliding_window_retransmit_tracker_top swt_checker u_swt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_func   (items.data.func),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res       (results.data)
);
